@@ rtl/ppe_pkg.sv @@
// ============================================================================
// ppe_pkg : shared types and constants of the particle pool engine
// Record layouts, operation codes, register indexes, hash and scale constants.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        FN_SPAWN = 2'd0,
        FN_TICK  = 2'd1,
        FN_SHIFT = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    // register indexes (paddr[2])
    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_OFFSET  = 1'b1;

    localparam logic [19:0] GRAVITY_RST = 20'd66560;
    localparam logic [15:0] OFFSET_RST  = 16'd2048;

    // lowbias32 hash and serial salt
    localparam logic [31:0] HASH_C1  = 32'h7feb352d;
    localparam logic [31:0] HASH_C2  = 32'h846ca68b;
    localparam logic [31:0] SALT_MUL = 32'd2654435761;

    // spawn value scaling, all divided by 65535 afterwards
    localparam logic [31:0] VX_SCALE   = 32'd3072;
    localparam logic [31:0] VY_SCALE   = 32'd2560;
    localparam logic [31:0] SPIN_SCALE = 32'd8960;
    localparam logic [31:0] LIFE_SCALE = 32'd4096;
    localparam logic [20:0] LIFE_BASE  = 21'd786420;
    localparam logic [33:0] HALF_DIV   = 34'd32767;
    localparam logic [33:0] LIFE_BIAS  = 34'd163837;
    localparam logic [18:0] DIV_K      = 19'd65535;
    localparam logic [31:0] DIV5_RECIP = 32'd52429;

    localparam logic [5:0] MAX_OUT = 6'd32;

    // one input word
    typedef struct packed {
        t_func              func;
        logic signed [23:0] spawn_x;
        logic signed [23:0] spawn_y;
        logic [15:0]        cell_mask;
        logic [15:0]        dt;
        logic signed [23:0] shift_dx;
    } t_in;

    // one output word
    typedef struct packed {
        logic [4:0]         slot;
        logic               valid_res;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] angle;
        logic [15:0]        age;
        logic [15:0]        life;
        logic               last;
    } t_out;

    // per-slot particle record
    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] rot;
        logic signed [23:0] spin;
        logic [15:0]        age;
        logic [15:0]        life;
    } t_rec;

    // saturate to 24-bit signed
    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607)
            return 24'sh7fffff;
        else if (v < -28'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ppe_mem.sv @@
// ============================================================================
// ppe_mem : particle record store
// One write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppe_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire ppe_pkg::t_rec   i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output ppe_pkg::t_rec        o_rdata
);
    import ppe_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, every cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/ppe_mul.sv @@
// ============================================================================
// ppe_mul : shared multiplier
// Signed 33 x 33 product, registered; result in the cycle after the operands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppe_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ rtl/ppe_seq.sv @@
// ============================================================================
// ppe_seq : particle pool sequencer
// Walks the slots for spawn, tick and shift, drives the shared multiplier,
// the record store and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppe_seq #(
    parameter int CAPACITY = 32,
    parameter int IW       = 5,
    parameter int CW       = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ppe_pkg::t_in       i_in,
    input  wire logic [19:0]        i_gravity,
    input  wire logic [15:0]        i_offset,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ppe_pkg::t_out           o_out,
    output logic                    o_mem_we,
    output logic [IW-1:0]           o_mem_waddr,
    output ppe_pkg::t_rec           o_mem_wdata,
    output logic [IW-1:0]           o_mem_raddr,
    input  wire ppe_pkg::t_rec      i_mem_rdata,
    output logic signed [32:0]      o_mul_a,
    output logic signed [32:0]      o_mul_b,
    input  wire logic signed [65:0] i_mul_p
);
    import ppe_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_PK_RD  = 21'h000002,
        S_PK_CMP = 21'h000004,
        S_SALT   = 21'h000008,
        S_SALTW  = 21'h000010,
        S_H0     = 21'h000020,
        S_H1     = 21'h000040,
        S_H2     = 21'h000080,
        S_D0     = 21'h000100,
        S_DIV    = 21'h000200,
        S_LIFE   = 21'h000400,
        S_SWB    = 21'h000800,
        S_TK_RD  = 21'h001000,
        S_TK_AGE = 21'h002000,
        S_TK_VY  = 21'h004000,
        S_TK_PX  = 21'h008000,
        S_TK_PY  = 21'h010000,
        S_TK_ROT = 21'h020000,
        S_TK_WB  = 21'h040000,
        S_SH_RD  = 21'h080000,
        S_SH_WB  = 21'h100000
    } t_state;

    // round a Q.24 product to Q.8 and add with saturation
    function automatic logic signed [23:0] step_add(input logic signed [23:0] base,
                                                    input logic signed [65:0] p);
        logic signed [41:0] ps;
        logic signed [41:0] sh;
        logic signed [27:0] s;
        ps = $signed(p[41:0]) + 42'sd32768;
        sh = ps >>> 16;
        s  = 28'(base) + sh[27:0];
        return sat24(s);
    endfunction

    t_state               r_state, n_state;
    logic [CW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_best, n_best;
    logic [16:0]          r_bleft, n_bleft;
    logic [5:0]           r_nrec, n_nrec;
    logic [CAPACITY-1:0]  r_snap, n_snap;
    logic [CAPACITY-1:0]  r_active, n_active;
    logic [31:0]          r_serial, n_serial;
    logic [31:0]          r_salt, n_salt;
    logic [1:0]           r_k, n_k;
    logic                 r_neg, n_neg;
    logic [17:0]          r_q, n_q;
    logic [18:0]          r_r, n_r;
    t_rec                 r_rec, n_rec;
    t_in                  r_in, n_in;
    logic                 r_ov, n_ov;
    t_out                 r_out, n_out;

    logic [IW-1:0]        idx_s;
    logic                 idx_last;
    logic                 out_free;
    logic [CAPACITY-1:0]  rest;
    logic                 is_last;
    logic [16:0]          dage;
    logic [16:0]          age_sum;
    logic [15:0]          age_new;
    logic [16:0]          left;
    logic [31:0]          hv;
    logic [31:0]          ht;
    logic [15:0]          hu;
    logic signed [17:0]   hd;
    logic [16:0]          hmag;
    logic [33:0]          dx;
    logic [17:0]          dq;
    logic signed [23:0]   qval;

    assign idx_s       = r_idx[IW-1:0];
    assign idx_last    = (r_idx == CW'(CAPACITY - 1));
    assign out_free    = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_mem_raddr = idx_s;

    // shared helpers
    always_comb begin
        rest    = r_snap >> r_idx;
        is_last = (r_nrec == (MAX_OUT - 6'd1)) || ((rest >> 1) == '0);
        dage    = ({1'b0, r_in.dt} + 17'd8) >> 4;
        age_sum = {1'b0, i_mem_rdata.age} + dage;
        age_new = age_sum[16] ? 16'hffff : age_sum[15:0];
        left    = {1'b0, i_mem_rdata.life} - {1'b0, i_mem_rdata.age};
        hv      = r_salt + 32'(r_k);
        ht      = i_mul_p[31:0];
        hu      = 16'(ht ^ (ht >> 16));
        hd      = $signed({1'b0, hu, 1'b0}) - 18'sd65535;
        hmag    = hd[17] ? 17'(-hd) : 17'(hd);
        dx      = i_mul_p[33:0] + ((r_k == 2'd3) ? LIFE_BIAS : HALF_DIV);
        dq      = dx[33:16];
        qval    = r_neg ? -24'(r_q) : 24'(r_q);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_best   = r_best;
        n_bleft  = r_bleft;
        n_nrec   = r_nrec;
        n_snap   = r_snap;
        n_active = r_active;
        n_serial = r_serial;
        n_salt   = r_salt;
        n_k      = r_k;
        n_neg    = r_neg;
        n_q      = r_q;
        n_r      = r_r;
        n_rec    = r_rec;
        n_in     = r_in;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = idx_s;
        o_mem_wdata = r_rec;
        o_mul_a     = '0;
        o_mul_b     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in  = i_in;
                    n_idx = '0;
                    case (i_in.func)
                        FN_SPAWN: begin
                            if (i_in.cell_mask != '0) begin
                                n_bleft = '1;
                                n_state = S_PK_RD;
                            end
                        end
                        FN_TICK: begin
                            if (i_in.dt != '0) begin
                                n_nrec  = '0;
                                n_snap  = r_active;
                                n_state = S_TK_RD;
                            end
                        end
                        FN_SHIFT: n_state = S_SH_RD;
                        default:  n_active = '0;
                    endcase
                end
            end

            // spawn: first free slot, else least remaining life
            S_PK_RD: begin
                if (!r_active[idx_s]) begin
                    n_best  = idx_s;
                    n_state = S_SALT;
                end else begin
                    n_state = S_PK_CMP;
                end
            end
            S_PK_CMP: begin
                if (left < r_bleft) begin
                    n_bleft = left;
                    n_best  = idx_s;
                end
                if (idx_last) begin
                    n_state = S_SALT;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_PK_RD;
                end
            end

            // serial and salt
            S_SALT: begin
                n_serial = r_serial + 32'd1;
                o_mul_a  = {1'b0, n_serial};
                o_mul_b  = {1'b0, SALT_MUL};
                n_state  = S_SALTW;
            end
            S_SALTW: begin
                n_salt  = i_mul_p[31:0];
                n_k     = '0;
                n_state = S_H0;
            end

            // lowbias32 rounds
            S_H0: begin
                o_mul_a = {1'b0, hv ^ (hv >> 16)};
                o_mul_b = {1'b0, HASH_C1};
                n_state = S_H1;
            end
            S_H1: begin
                o_mul_a = {1'b0, ht ^ (ht >> 15)};
                o_mul_b = {1'b0, HASH_C2};
                n_state = S_H2;
            end
            S_H2: begin
                case (r_k)
                    2'd0: begin
                        n_neg   = hd[17];
                        o_mul_a = 33'(hmag);
                        o_mul_b = {1'b0, VX_SCALE};
                    end
                    2'd1: begin
                        n_neg   = 1'b0;
                        o_mul_a = 33'(hu);
                        o_mul_b = {1'b0, VY_SCALE};
                    end
                    2'd2: begin
                        n_neg   = hd[17];
                        o_mul_a = 33'(hmag);
                        o_mul_b = {1'b0, SPIN_SCALE};
                    end
                    default: begin
                        n_neg   = 1'b0;
                        o_mul_a = 33'(LIFE_BASE + {2'b0, hu, 3'b0});
                        o_mul_b = {1'b0, LIFE_SCALE};
                    end
                endcase
                n_state = S_D0;
            end

            // divide by 65535: fold high half, then correct
            S_D0: begin
                n_q     = dq;
                n_r     = 19'(dx[15:0]) + 19'(dq);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_r >= DIV_K) begin
                    n_r = r_r - DIV_K;
                    n_q = r_q + 18'd1;
                end else if (r_k == 2'd3) begin
                    o_mul_a = 33'(r_q);
                    o_mul_b = {1'b0, DIV5_RECIP};
                    n_state = S_LIFE;
                end else begin
                    case (r_k)
                        2'd0:    n_rec.vx   = qval;
                        2'd1:    n_rec.vy   = qval;
                        default: n_rec.spin = qval;
                    endcase
                    n_k     = r_k + 2'd1;
                    n_state = S_H0;
                end
            end
            S_LIFE: begin
                n_rec.life = i_mul_p[33:18];
                n_state    = S_SWB;
            end

            // spawn write-back and report
            S_SWB: begin
                o_mem_wdata     = r_rec;
                o_mem_wdata.px  = sat24(28'(r_in.spawn_x) + 28'(i_offset));
                o_mem_wdata.py  = sat24(28'(r_in.spawn_y) + 28'(i_offset));
                o_mem_wdata.rot = '0;
                o_mem_wdata.age = '0;
                o_mem_waddr     = r_best;
                if (out_free) begin
                    o_mem_we           = 1'b1;
                    n_active[r_best]   = 1'b1;
                    n_ov               = 1'b1;
                    n_out.slot         = 5'(r_best);
                    n_out.valid_res    = 1'b1;
                    n_out.pos_x        = o_mem_wdata.px;
                    n_out.pos_y        = o_mem_wdata.py;
                    n_out.angle        = '0;
                    n_out.age          = '0;
                    n_out.life         = r_rec.life;
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            // tick: age, retire, integrate
            S_TK_RD: begin
                if (r_active[idx_s]) begin
                    n_state = S_TK_AGE;
                end else if (idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_TK_AGE: begin
                o_mul_a = 33'(i_gravity);
                o_mul_b = 33'(r_in.dt);
                if (age_new >= i_mem_rdata.life) begin
                    if (r_nrec >= MAX_OUT || out_free) begin
                        n_active[idx_s] = 1'b0;
                        if (r_nrec < MAX_OUT) begin
                            n_ov            = 1'b1;
                            n_out           = '0;
                            n_out.slot      = 5'(r_idx);
                            n_out.last      = is_last;
                            n_nrec          = r_nrec + 6'd1;
                        end
                        if (idx_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = S_TK_RD;
                        end
                    end
                end else begin
                    n_rec     = i_mem_rdata;
                    n_rec.age = age_new;
                    n_state   = S_TK_VY;
                end
            end
            S_TK_VY: begin
                n_rec.vy = step_add(r_rec.vy, i_mul_p);
                o_mul_a  = 33'(r_rec.vx);
                o_mul_b  = 33'(r_in.dt);
                n_state  = S_TK_PX;
            end
            S_TK_PX: begin
                n_rec.px = step_add(r_rec.px, i_mul_p);
                o_mul_a  = 33'(r_rec.vy);
                o_mul_b  = 33'(r_in.dt);
                n_state  = S_TK_PY;
            end
            S_TK_PY: begin
                n_rec.py = step_add(r_rec.py, i_mul_p);
                o_mul_a  = 33'(r_rec.spin);
                o_mul_b  = 33'(r_in.dt);
                n_state  = S_TK_ROT;
            end
            S_TK_ROT: begin
                n_rec.rot = step_add(r_rec.rot, i_mul_p);
                n_state   = S_TK_WB;
            end
            S_TK_WB: begin
                if (r_nrec >= MAX_OUT || out_free) begin
                    o_mem_we = 1'b1;
                    if (r_nrec < MAX_OUT) begin
                        n_ov            = 1'b1;
                        n_out.slot      = 5'(r_idx);
                        n_out.valid_res = 1'b1;
                        n_out.pos_x     = r_rec.px;
                        n_out.pos_y     = r_rec.py;
                        n_out.angle     = r_rec.rot;
                        n_out.age       = r_rec.age;
                        n_out.life      = r_rec.life;
                        n_out.last      = is_last;
                        n_nrec          = r_nrec + 6'd1;
                    end
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_TK_RD;
                    end
                end
            end

            // shift: live slots only, free slots are rewritten on spawn
            S_SH_RD: begin
                if (r_active[idx_s]) begin
                    n_state = S_SH_WB;
                end else if (idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SH_WB: begin
                o_mem_we       = 1'b1;
                o_mem_wdata    = i_mem_rdata;
                o_mem_wdata.px = sat24(28'(i_mem_rdata.px) + 28'(r_in.shift_dx));
                if (idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SH_RD;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_serial <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_serial <= n_serial;
            r_ov     <= n_ov;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_bleft <= n_bleft;
        r_nrec  <= n_nrec;
        r_snap  <= n_snap;
        r_salt  <= n_salt;
        r_k     <= n_k;
        r_neg   <= n_neg;
        r_q     <= n_q;
        r_r     <= n_r;
        r_rec   <= n_rec;
        r_in    <= n_in;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

@@ rtl/particle_pool_engine.sv @@
// ============================================================================
// particle_pool_engine : fixed pool of falling particles
// Spawn, tick (semi-implicit Euler), shift and clear over a slot store,
// with one shared multiplier under a sequencer.
// ============================================================================
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid / tready        | tdata fields, tuser = func
//  m_axis    | out       | tvalid / tready / tlast| tdata fields, tuser = valid_res
//  apb       | in        | psel / penable / pready| gravity @0x0, spawn_offset @0x4
//
//  Spawn: each live slot searched is read and compared, and a free slot ends
//  the search; then the hash and divide work runs in the shared multiplier,
//  with the divide correction step repeated as often as the remainder needs.
//  Tick: free slots are skipped, a surviving live slot is read, aged, integrated
//  and written back, a retiring one is read and retired; shift rewrites live slots.
//  The multiplier and the single record port set this order of steps.
//  Reset is synchronous, active low; the pool starts empty.
//  A stalled output word holds the sequencer only when a new word is ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module particle_pool_engine #(
    parameter int CAPACITY = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // spawn_x[23:0], spawn_y[47:24], cell_mask[63:48], dt[79:64], shift_dx[103:80]
    input  wire logic [103:0]  i_s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]    i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // slot[4:0], pos_x[28:5], pos_y[52:29], angle[76:53], age[92:77],
    // life[108:93], zero[111:109]
    output logic [111:0]       o_m_axis_tdata,
    // valid_res[0]
    output logic               o_m_axis_tuser,
    output logic               o_m_axis_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ppe_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [19:0]        r_gravity;
    logic [15:0]        r_offset;
    t_in                in_word;
    t_out               out_word;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [IW-1:0]      mem_raddr;
    t_rec               mem_wdata;
    t_rec               mem_rdata;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RST;
            r_offset  <= OFFSET_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_OFFSET)
                r_offset <= pwdata[15:0];
            else
                r_gravity <= pwdata[19:0];
        end
    end
    assign prdata = (paddr[2] == REG_GRAVITY) ? {12'b0, r_gravity} : {16'b0, r_offset};

    // unpack input word
    always_comb begin
        in_word.func      = t_func'(i_s_axis_tuser);
        in_word.spawn_x   = i_s_axis_tdata[23:0];
        in_word.spawn_y   = i_s_axis_tdata[47:24];
        in_word.cell_mask = i_s_axis_tdata[63:48];
        in_word.dt        = i_s_axis_tdata[79:64];
        in_word.shift_dx  = i_s_axis_tdata[103:80];
    end

    // pack output word
    assign o_m_axis_tdata = {3'b0, out_word.life, out_word.age, out_word.angle,
                             out_word.pos_y, out_word.pos_x, out_word.slot};
    assign o_m_axis_tuser = out_word.valid_res;
    assign o_m_axis_tlast = out_word.last;

    ppe_seq #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in        (in_word),
        .i_gravity   (r_gravity),
        .i_offset    (r_offset),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (out_word),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_mul_a     (mul_a),
        .o_mul_b     (mul_b),
        .i_mul_p     (mul_p)
    );

    ppe_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ppe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

endmodule

`default_nettype wire

@@ rtl/ppe_checker.sv @@
// ============================================================================
// ppe_checker : port-level checks of the particle pool engine
// Watches the stream and register ports; bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppe_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [103:0] i_s_axis_tdata,
    input wire logic [1:0]   i_s_axis_tuser,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [111:0] o_m_axis_tdata,
    input wire logic         o_m_axis_tuser,
    input wire logic         pready
);
    import ppe_pkg::*;

    // nothing leaves the block straight after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    // a real tick or spawn keeps the input closed for its work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
        ((i_s_axis_tuser == FN_TICK && i_s_axis_tdata[79:64] != 16'd0) ||
         (i_s_axis_tuser == FN_SPAWN && i_s_axis_tdata[63:48] != 16'd0))
        |=> !o_s_axis_tready)
        else $error("input taken while a word is in work");

    // a retired-slot word carries only its slot
    a_retire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[111:5] == '0)
        else $error("retired slot word with non-zero fields");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind particle_pool_engine ppe_checker u_ppe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .pready          (pready)
);

`default_nettype wire
